/* rtl/plfs_pkg.sv */
// Package for the point light fragment shader: widths, register indexes,
// light slot layout, unit request/response structs and small helpers.
// No dependencies.
`default_nettype none
package plfs_pkg;

    localparam int MAX_LIGHTS_DEF = 8;
    localparam int CHAN_W = 16;
    localparam int POS_W  = 32;
    localparam int DSQ_W  = 64;
    localparam int ROOT_W = 32;
    localparam int ATT_W  = 60;
    localparam int NUM_W  = 36;
    localparam int LACC_W = 14;
    localparam int S_DATA_W = 216;
    localparam int M_DATA_W = 64;
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    // Configuration register indexes, taken from paddr[5:3].
    localparam logic [2:0] REG_AMBIENT  = 3'd0;
    localparam logic [2:0] REG_EMISSIVE = 3'd1;
    localparam logic [2:0] REG_DIFFUSE  = 3'd2;
    localparam logic [2:0] REG_TEXEL    = 3'd3;
    localparam logic [2:0] REG_LCOUNT   = 3'd4;

    // Input kinds carried on tuser.
    localparam logic KIND_LIGHT = 1'b0;
    localparam logic KIND_FRAG  = 1'b1;

    localparam logic [LACC_W-1:0] ONE_Q12  = LACC_W'(4096);
    localparam logic [LACC_W-1:0] LACC_MAX = '1;

    typedef struct packed {
        logic              is_point;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [63:0]       color;
        logic [47:0]       atten;
    } light_entry_t;

    typedef struct packed {
        logic             start;
        logic [DSQ_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [ATT_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

    // One Q4.12 channel of a packed RGBA word.
    function automatic logic [CHAN_W-1:0] chan(input logic [63:0] w, input logic [1:0] k);
        return w[k*CHAN_W +: CHAN_W];
    endfunction

    // Product of two Q4.12 values, scaled back and saturated.
    function automatic logic [CHAN_W-1:0] sat_q12(input logic [63:0] p);
        return (p[63:28] != '0) ? '1 : p[27:12];
    endfunction

    // Light accumulator add; saturates well above 1.0 since it is clamped later.
    function automatic logic [LACC_W-1:0] acc_add(input logic [LACC_W-1:0] a,
                                                  input logic [NUM_W-1:0] b);
        logic [NUM_W:0] s;
        s = (NUM_W+1)'(a) + (NUM_W+1)'(b);
        return (s > (NUM_W+1)'(LACC_MAX)) ? LACC_MAX : s[LACC_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/plfs_sqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
// Depends on plfs_pkg.
`default_nettype none
module plfs_sqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  plfs_pkg::sqrt_req_t req,
    output plfs_pkg::sqrt_rsp_t rsp
);
    import plfs_pkg::*;

    logic [DSQ_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;

    // One digit step: bring down two bits and try 4*root+1.
    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, rad_reg[DSQ_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        if (req.start) begin
            rad_next  = req.radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[DSQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = (ROOT_W+2)'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[ROOT_W+1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == '1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp = '{busy: busy_reg, done: done_reg, root: root_reg};

endmodule
`default_nettype wire

/* rtl/plfs_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on plfs_pkg.
`default_nettype none
module plfs_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  plfs_pkg::div_req_t req,
    output plfs_pkg::div_rsp_t rsp
);
    import plfs_pkg::*;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [ATT_W-1:0] rem_reg, rem_next;
    logic [ATT_W-1:0] den_reg, den_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ATT_W:0]   rem_sh;

    // Shift the next dividend bit into the remainder and try a subtract.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, quo_reg[NUM_W-1]};
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next = ATT_W'(rem_sh - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[ATT_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp = '{busy: busy_reg, done: done_reg, quot: quo_reg};

endmodule
`default_nettype wire

/* rtl/point_light_fragment_shader.sv */
// Top level of the point light fragment shader: beat handling, APB registers,
// light slot memory and the sequencer. Depends on plfs_pkg, plfs_sqrt, plfs_div.
`default_nettype none
// A light write beat (tuser = 0) is taken while the block is idle and stores
// a slot if its index is below MAX_LIGHTS. A fragment beat (tuser = 1) runs
// on one shared 32x32 multiplier, a 32-step square root unit and a 36-step
// divider under a small sequencer, and the block is not ready until its result
// sits in the output register. Slots that hold no point light are skipped and
// a point light whose attenuation is zero needs no division; otherwise the
// three per-channel divisions dominate its time. Results wait in an output
// register, so the next beat is taken while one is pending.
module point_light_fragment_shader #(
    parameter int MAX_LIGHTS = plfs_pkg::MAX_LIGHTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // light_slot[2:0], is_point[3], pos_x[35:4], pos_y[67:36], pos_z[99:68],
    // rgba[163:100], atten_coeffs[211:164], zero pad
    input  logic [plfs_pkg::S_DATA_W-1:0] s_tdata,
    // kind[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_r[15:0], out_g[31:16], out_b[47:32], out_a[63:48]
    output logic [plfs_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plfs_pkg::APB_AW-1:0]   paddr,
    input  logic [plfs_pkg::APB_DW-1:0]   pwdata,
    output logic [plfs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import plfs_pkg::*;

    localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CW = $clog2(MAX_LIGHTS + 1);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_EMIS_MUL = 5'd1;
    localparam logic [4:0] ST_EMIS_ACC = 5'd2;
    localparam logic [4:0] ST_LREAD    = 5'd3;
    localparam logic [4:0] ST_LWAIT    = 5'd4;
    localparam logic [4:0] ST_DSQ_MUL  = 5'd5;
    localparam logic [4:0] ST_DSQ_ACC  = 5'd6;
    localparam logic [4:0] ST_SQRT     = 5'd7;
    localparam logic [4:0] ST_ATT_M1   = 5'd8;
    localparam logic [4:0] ST_ATT_M2   = 5'd9;
    localparam logic [4:0] ST_ATT_M3   = 5'd10;
    localparam logic [4:0] ST_ATT_M4   = 5'd11;
    localparam logic [4:0] ST_COL_MUL  = 5'd12;
    localparam logic [4:0] ST_COL_DIV  = 5'd13;
    localparam logic [4:0] ST_DIV_WAIT = 5'd14;
    localparam logic [4:0] ST_FIN1     = 5'd15;
    localparam logic [4:0] ST_FIN2     = 5'd16;
    localparam logic [4:0] ST_FIN3     = 5'd17;
    localparam logic [4:0] ST_FIN4     = 5'd18;
    localparam logic [4:0] ST_FIN5     = 5'd19;
    localparam logic [4:0] ST_FIN6     = 5'd20;
    localparam logic [4:0] ST_OUT      = 5'd21;

    // Beat fields.
    logic              in_kind;
    logic [2:0]        in_slot;
    light_entry_t      in_entry;
    logic              in_accept;
    logic              slot_ok;

    assign in_kind   = s_tuser[0];
    assign in_slot   = s_tdata[2:0];
    assign in_entry  = '{is_point: s_tdata[3], pos_x: s_tdata[35:4],
                         pos_y: s_tdata[67:36], pos_z: s_tdata[99:68],
                         color: s_tdata[163:100], atten: s_tdata[211:164]};
    assign in_accept = s_tvalid && s_tready;
    assign slot_ok   = 7'(in_slot) < 7'(MAX_LIGHTS);

    // Configuration registers.
    logic [47:0] ambient_reg;
    logic [63:0] emissive_reg, diffuse_reg, texel_reg;
    logic [3:0]  lcount_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ambient_reg  <= '0;
            emissive_reg <= '0;
            diffuse_reg  <= '0;
            texel_reg    <= '0;
            lcount_reg   <= '0;
        end else if (cfg_write) begin
            case (paddr[5:3])
                REG_AMBIENT:  ambient_reg  <= pwdata[47:0];
                REG_EMISSIVE: emissive_reg <= pwdata;
                REG_DIFFUSE:  diffuse_reg  <= pwdata;
                REG_TEXEL:    texel_reg    <= pwdata;
                REG_LCOUNT:   lcount_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[5:3])
            REG_AMBIENT:  prdata = 64'(ambient_reg);
            REG_EMISSIVE: prdata = emissive_reg;
            REG_DIFFUSE:  prdata = diffuse_reg;
            REG_TEXEL:    prdata = texel_reg;
            REG_LCOUNT:   prdata = 64'(lcount_reg);
            default:      prdata = '0;
        endcase
    end

    // Sequencer state.
    logic [4:0]        state_reg, state_next;
    logic [1:0]        k_reg, k_next;
    logic [CW-1:0]     li_reg, li_next;
    logic [63:0]       prod_reg, prod_next;
    logic [DSQ_W-1:0]  dsq_reg, dsq_next;
    logic [ATT_W-1:0]  att_reg, att_next;
    logic [LACC_W-1:0] light_reg [3];
    logic [LACC_W-1:0] light_next [3];
    logic [CHAN_W-1:0] t_reg, t_next;
    logic [CHAN_W-1:0] res_reg [4];
    logic [CHAN_W-1:0] res_next [4];
    logic [POS_W-1:0]  fx_reg, fy_reg, fz_reg;
    logic [63:0]       frag_rgba_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg, m_tdata_next;
    light_entry_t      entry_reg;
    light_entry_t      light_mem [MAX_LIGHTS];

    logic [CW-1:0]     n_lim;
    logic [31:0]       mul_a, mul_b;
    logic [POS_W-1:0]  f_axis, l_axis;
    logic [POS_W:0]    delta;
    logic [POS_W-1:0]  mag;
    logic [LACC_W-1:0] l_clamp;
    logic [15:0]       c0, c1, c2;
    sqrt_req_t         sqrt_req;
    sqrt_rsp_t         sqrt_rsp;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign n_lim = (7'(lcount_reg) > 7'(MAX_LIGHTS)) ? CW'(MAX_LIGHTS) : CW'(lcount_reg);
    assign c0 = entry_reg.atten[15:0];
    assign c1 = entry_reg.atten[31:16];
    assign c2 = entry_reg.atten[47:32];
    assign l_clamp = (light_reg[k_reg] > ONE_Q12) ? ONE_Q12 : light_reg[k_reg];

    // Light slot memory: written by light beats, read one slot per visit.
    always_ff @(posedge aclk) begin
        if (in_accept && (in_kind == KIND_LIGHT) && slot_ok) begin
            light_mem[AW'(7'(in_slot))] <= in_entry;
        end
        if (state_reg == ST_LREAD) begin
            entry_reg <= light_mem[li_reg[AW-1:0]];
        end
    end

    // Per-axis distance magnitude.
    always_comb begin
        case (k_reg)
            2'd0:    begin f_axis = fx_reg; l_axis = entry_reg.pos_x; end
            2'd1:    begin f_axis = fy_reg; l_axis = entry_reg.pos_y; end
            default: begin f_axis = fz_reg; l_axis = entry_reg.pos_z; end
        endcase
        delta = {f_axis[POS_W-1], f_axis} - {l_axis[POS_W-1], l_axis};
        mag   = delta[POS_W] ? POS_W'(-delta) : delta[POS_W-1:0];
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_EMIS_MUL: begin
                mul_a = 32'(chan(emissive_reg, k_reg));
                mul_b = 32'(chan(emissive_reg, 2'd3));
            end
            ST_DSQ_MUL: begin
                mul_a = mag;
                mul_b = mag;
            end
            ST_ATT_M1: begin
                mul_a = 32'(c1);
                mul_b = sqrt_rsp.root;
            end
            ST_ATT_M2: begin
                mul_a = 32'(c2);
                mul_b = dsq_reg[63:32];
            end
            ST_ATT_M3: begin
                mul_a = 32'(c2);
                mul_b = dsq_reg[31:0];
            end
            ST_COL_MUL: begin
                mul_a = 32'(chan(entry_reg.color, k_reg));
                mul_b = 32'(chan(entry_reg.color, 2'd3));
            end
            ST_FIN1: begin
                mul_a = 32'(chan(diffuse_reg, k_reg));
                mul_b = 32'(chan(frag_rgba_reg, k_reg));
            end
            ST_FIN3: begin
                mul_a = 32'(t_reg);
                mul_b = 32'(chan(texel_reg, k_reg));
            end
            ST_FIN5: begin
                mul_a = 32'(t_reg);
                mul_b = 32'(l_clamp);
            end
            default: ;
        endcase
        prod_next = {32'b0, mul_a} * {32'b0, mul_b};
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        li_next       = li_reg;
        dsq_next      = dsq_reg;
        att_next      = att_reg;
        light_next    = light_reg;
        t_next        = t_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        sqrt_req      = '{start: 1'b0, radicand: dsq_reg};
        div_req       = '{start: 1'b0, num: {prod_reg[31:0], 4'b0000}, den: att_reg};
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (in_kind == KIND_FRAG)) begin
                    k_next     = '0;
                    state_next = ST_EMIS_MUL;
                end
            end
            ST_EMIS_MUL: state_next = ST_EMIS_ACC;
            ST_EMIS_ACC: begin
                light_next[k_reg] = acc_add('0, NUM_W'(chan({16'b0, ambient_reg}, k_reg))
                                               + NUM_W'(prod_reg[31:12]));
                if (k_reg == 2'd2) begin
                    li_next    = '0;
                    state_next = ST_LREAD;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_EMIS_MUL;
                end
            end
            ST_LREAD: begin
                if (li_reg == n_lim) begin
                    k_next     = '0;
                    state_next = ST_FIN1;
                end else begin
                    state_next = ST_LWAIT;
                end
            end
            ST_LWAIT: begin
                if (!entry_reg.is_point) begin
                    li_next    = li_reg + CW'(1);
                    state_next = ST_LREAD;
                end else begin
                    dsq_next   = '0;
                    k_next     = '0;
                    state_next = ST_DSQ_MUL;
                end
            end
            ST_DSQ_MUL: state_next = ST_DSQ_ACC;
            ST_DSQ_ACC: begin
                dsq_next = dsq_reg + {2'b00, prod_reg[63:2]};
                if (k_reg == 2'd2) begin
                    sqrt_req   = '{start: 1'b1, radicand: dsq_next};
                    state_next = ST_SQRT;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_DSQ_MUL;
                end
            end
            ST_SQRT: begin
                if (sqrt_rsp.done) begin
                    state_next = ST_ATT_M1;
                end
            end
            ST_ATT_M1: state_next = ST_ATT_M2;
            ST_ATT_M2: begin
                att_next   = (ATT_W'(c0) << 8) + ATT_W'(prod_reg[63:7]);
                state_next = ST_ATT_M3;
            end
            ST_ATT_M3: begin
                att_next   = att_reg + (ATT_W'(prod_reg[47:0]) << 10);
                state_next = ST_ATT_M4;
            end
            ST_ATT_M4: begin
                att_next   = att_reg + ATT_W'(prod_reg[63:22]);
                k_next     = '0;
                state_next = ST_COL_MUL;
            end
            ST_COL_MUL: state_next = ST_COL_DIV;
            ST_COL_DIV: begin
                if (att_reg == '0) begin
                    // A zero attenuation contributes full light.
                    light_next[k_reg] = acc_add(light_reg[k_reg], NUM_W'(ONE_Q12));
                    if (k_reg == 2'd2) begin
                        li_next    = li_reg + CW'(1);
                        state_next = ST_LREAD;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_COL_MUL;
                    end
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    light_next[k_reg] = acc_add(light_reg[k_reg], div_rsp.quot);
                    if (k_reg == 2'd2) begin
                        li_next    = li_reg + CW'(1);
                        state_next = ST_LREAD;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_COL_MUL;
                    end
                end
            end
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: begin
                t_next     = sat_q12(prod_reg);
                state_next = ST_FIN3;
            end
            ST_FIN3: state_next = ST_FIN4;
            ST_FIN4: begin
                t_next = sat_q12(prod_reg);
                if (k_reg == 2'd3) begin
                    res_next[3] = sat_q12(prod_reg);
                    state_next  = ST_OUT;
                end else begin
                    state_next = ST_FIN5;
                end
            end
            ST_FIN5: state_next = ST_FIN6;
            ST_FIN6: begin
                res_next[k_reg] = prod_reg[27:12];
                k_next          = k_reg + 2'd1;
                state_next      = ST_FIN1;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            li_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            li_reg       <= li_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        prod_reg    <= prod_next;
        dsq_reg     <= dsq_next;
        att_reg     <= att_next;
        light_reg   <= light_next;
        t_reg       <= t_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
        if (in_accept && (in_kind == KIND_FRAG)) begin
            fx_reg        <= in_entry.pos_x;
            fy_reg        <= in_entry.pos_y;
            fz_reg        <= in_entry.pos_z;
            frag_rgba_reg <= in_entry.color;
        end
    end

    plfs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    plfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // The divider is never restarted while a division is running.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // The root unit picks up a start at once.
    a_sqrt_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_req.start |=> sqrt_rsp.busy)
        else $error("square root unit missed its start");

    // The slot walk never runs past the active light count.
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LREAD) |-> (li_reg <= n_lim))
        else $error("light index past light count");

    // A fragment beat starts the emissive pass in the next cycle.
    a_frag_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (in_kind == KIND_FRAG)) |=> (state_reg == ST_EMIS_MUL))
        else $error("fragment beat did not start shading");
`endif

endmodule
`default_nettype wire
